[rtl/cmp_pkg.sv]
// Shared constants, beat type and arctangent table for the magnitude/phase pipeline.
package cmp_pkg;

  // Sample width and number of micro-rotation stages
  localparam int DATA_WIDTH  = 16;
  localparam int ITERATIONS  = 16;
  localparam int ATAN_COUNT  = 24;
  localparam int NUM_STAGES  = (ITERATIONS < ATAN_COUNT) ? ITERATIONS : ATAN_COUNT;

  // Datapath widths
  localparam int GUARD       = 8;
  localparam int XY_W        = DATA_WIDTH + GUARD + 3;
  localparam int Z_W         = 34;
  localparam int MAG_W       = 16;
  localparam int ANG_W       = 16;
  localparam int GAIN_W      = 22;
  localparam int PROD_W      = XY_W - 1 + GAIN_W;
  localparam int MAG_SHIFT   = GUARD + 22;
  localparam int Z_SHIFT     = 17;
  localparam int ZR_W        = Z_W - Z_SHIFT;

  // Stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((MAG_W + ANG_W + 7) / 8) * 8;

  // Numeric constants
  localparam int GAIN_Q22    = 2547003;
  localparam int MAG_MAX     = 46341;
  localparam int PI_Q13      = 25736;
  localparam int HALF_PI_Q13 = 12868;
  localparam int HALF_PI_Q30 = 1686629713;
  localparam int Z_ROUND     = 65536;

  // atan(2^-i) in Q30 radians
  localparam int ATAN_Q30 [ATAN_COUNT] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  // One beat travelling down the pipeline
  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
    logic                    special;
    logic        [MAG_W-1:0] sp_mag;
    logic        [ANG_W-1:0] sp_ang;
  } cmp_beat_t;

endpackage

[rtl/cmp_prerot.sv]
// Entry stage: axis detection and rotation of left half-plane samples into the right half-plane.
module cmp_prerot (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [cmp_pkg::DATA_WIDTH-1:0] re_part,
  input  logic signed [cmp_pkg::DATA_WIDTH-1:0] im_part,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cmp_pkg::cmp_beat_t                  out_beat
);

  logic signed [cmp_pkg::DATA_WIDTH:0] re_x;
  logic signed [cmp_pkg::DATA_WIDTH:0] im_x;
  logic signed [cmp_pkg::DATA_WIDTH:0] re_neg;
  logic signed [cmp_pkg::DATA_WIDTH:0] im_neg;
  logic signed [cmp_pkg::DATA_WIDTH:0] x0;
  logic signed [cmp_pkg::DATA_WIDTH:0] y0;
  logic signed [cmp_pkg::DATA_WIDTH:0] axis_abs;
  logic                                re_zero;
  logic                                im_zero;
  cmp_pkg::cmp_beat_t                  beat_next;

  // Widen by one bit so that negating the most negative value is exact
  always_comb begin
    re_x    = {re_part[cmp_pkg::DATA_WIDTH-1], re_part};
    im_x    = {im_part[cmp_pkg::DATA_WIDTH-1], im_part};
    re_neg  = -re_x;
    im_neg  = -im_x;
    re_zero = (re_part == '0);
    im_zero = (im_part == '0);
  end

  // Pick the starting vector and angle offset by half-plane
  always_comb begin
    beat_next = '0;
    if (!re_x[cmp_pkg::DATA_WIDTH]) begin
      x0          = re_x;
      y0          = im_x;
      beat_next.z = '0;
    end else if (!im_x[cmp_pkg::DATA_WIDTH]) begin
      x0          = im_x;
      y0          = re_neg;
      beat_next.z = cmp_pkg::Z_W'(cmp_pkg::HALF_PI_Q30);
    end else begin
      x0          = im_neg;
      y0          = re_x;
      beat_next.z = cmp_pkg::Z_W'(-cmp_pkg::HALF_PI_Q30);
    end
    beat_next.x = cmp_pkg::XY_W'(x0) <<< cmp_pkg::GUARD;
    beat_next.y = cmp_pkg::XY_W'(y0) <<< cmp_pkg::GUARD;

    // Samples on an axis bypass the rotations
    beat_next.special = re_zero || im_zero;
    if (im_zero) begin
      axis_abs         = re_x[cmp_pkg::DATA_WIDTH] ? re_neg : re_x;
      beat_next.sp_ang = re_x[cmp_pkg::DATA_WIDTH] ? cmp_pkg::ANG_W'(cmp_pkg::PI_Q13) : '0;
    end else begin
      axis_abs         = im_x[cmp_pkg::DATA_WIDTH] ? im_neg : im_x;
      beat_next.sp_ang = im_x[cmp_pkg::DATA_WIDTH] ? cmp_pkg::ANG_W'(-cmp_pkg::HALF_PI_Q13)
                                                   : cmp_pkg::ANG_W'(cmp_pkg::HALF_PI_Q13);
    end
    if (axis_abs > cmp_pkg::MAG_MAX) begin
      beat_next.sp_mag = cmp_pkg::MAG_W'(cmp_pkg::MAG_MAX);
    end else begin
      beat_next.sp_mag = cmp_pkg::MAG_W'(axis_abs);
    end
  end

  assign in_ready = !out_valid || out_ready;

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_beat <= beat_next;
    end
  end

endmodule

[rtl/cmp_cordic.sv]
// Vectoring CORDIC: one registered micro-rotation per stage, each stage with its own handshake.
module cmp_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cmp_pkg::cmp_beat_t in_beat,
  output logic               out_valid,
  input  logic               out_ready,
  output cmp_pkg::cmp_beat_t out_beat
);

  localparam int N = cmp_pkg::NUM_STAGES;

  logic               valid [N+1];
  logic               ready [N+1];
  cmp_pkg::cmp_beat_t beat  [N+1];

  assign valid[0]  = in_valid;
  assign beat[0]   = in_beat;
  assign in_ready  = ready[0];
  assign ready[N]  = out_ready;
  assign out_valid = valid[N];
  assign out_beat  = beat[N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic signed [cmp_pkg::XY_W-1:0] xc;
    logic signed [cmp_pkg::XY_W-1:0] yc;
    logic signed [cmp_pkg::XY_W-1:0] dx;
    logic signed [cmp_pkg::XY_W-1:0] dy;
    cmp_pkg::cmp_beat_t              nxt;

    // Rotate towards the x axis by atan(2^-k)
    always_comb begin
      xc  = beat[k].x;
      yc  = beat[k].y;
      dx  = yc >>> k;
      dy  = xc >>> k;
      nxt = beat[k];
      if (!yc[cmp_pkg::XY_W-1]) begin
        nxt.x = xc + dx;
        nxt.y = yc - dy;
        nxt.z = beat[k].z + cmp_pkg::Z_W'(cmp_pkg::ATAN_Q30[k]);
      end else begin
        nxt.x = xc - dx;
        nxt.y = yc + dy;
        nxt.z = beat[k].z - cmp_pkg::Z_W'(cmp_pkg::ATAN_Q30[k]);
      end
    end

    // Take a beat when this stage is empty or drains this cycle
    assign ready[k] = !valid[k+1] || ready[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (ready[k]) begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ready[k] && valid[k]) begin
        beat[k+1] <= nxt;
      end
    end
  end

endmodule

[rtl/cmp_post.sv]
// Gain correction, rounding, saturation and output register.
module cmp_post (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  cmp_pkg::cmp_beat_t      in_beat,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [cmp_pkg::MAG_W-1:0] magnitude,
  output logic [cmp_pkg::ANG_W-1:0] angle
);

  localparam int MAG_FULL_W = cmp_pkg::PROD_W - cmp_pkg::MAG_SHIFT;

  // Multiply stage
  logic                              a_valid;
  logic                              a_ready;
  logic        [cmp_pkg::PROD_W-1:0] a_prod;
  logic signed [cmp_pkg::ZR_W-1:0]   a_zr;
  logic                              a_special;
  logic        [cmp_pkg::MAG_W-1:0]  a_sp_mag;
  logic        [cmp_pkg::ANG_W-1:0]  a_sp_ang;

  logic        [cmp_pkg::XY_W-2:0]   x_pos;
  logic        [cmp_pkg::GAIN_W-1:0] gain;
  logic        [cmp_pkg::PROD_W-1:0] prod;
  logic signed [cmp_pkg::Z_W-1:0]    z_sum;

  // Output stage
  logic        [cmp_pkg::PROD_W-1:0] mag_sum;
  logic        [MAG_FULL_W-1:0]      mag_full;
  logic        [cmp_pkg::MAG_W-1:0]  mag_next;
  logic        [cmp_pkg::ANG_W-1:0]  ang_next;

  // Clip negative x, scale by 1/K, round the angle to Q13
  always_comb begin
    x_pos = in_beat.x[cmp_pkg::XY_W-1] ? '0 : in_beat.x[cmp_pkg::XY_W-2:0];
    gain  = cmp_pkg::GAIN_W'(cmp_pkg::GAIN_Q22);
    prod  = cmp_pkg::PROD_W'(x_pos) * cmp_pkg::PROD_W'(gain);
    z_sum = in_beat.z + cmp_pkg::Z_W'(cmp_pkg::Z_ROUND);
  end

  assign in_ready = !a_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_prod    <= prod;
      a_zr      <= z_sum[cmp_pkg::Z_W-1:cmp_pkg::Z_SHIFT];
      a_special <= in_beat.special;
      a_sp_mag  <= in_beat.sp_mag;
      a_sp_ang  <= in_beat.sp_ang;
    end
  end

  // Round and saturate magnitude, clamp angle, select axis results
  always_comb begin
    mag_sum  = a_prod + (cmp_pkg::PROD_W'(1) << (cmp_pkg::MAG_SHIFT - 1));
    mag_full = mag_sum[cmp_pkg::PROD_W-1:cmp_pkg::MAG_SHIFT];
    if (a_special) begin
      mag_next = a_sp_mag;
      ang_next = a_sp_ang;
    end else begin
      if (mag_full > cmp_pkg::MAG_MAX) begin
        mag_next = cmp_pkg::MAG_W'(cmp_pkg::MAG_MAX);
      end else begin
        mag_next = cmp_pkg::MAG_W'(mag_full);
      end
      priority if (a_zr > cmp_pkg::PI_Q13) begin
        ang_next = cmp_pkg::ANG_W'(cmp_pkg::PI_Q13);
      end else if (a_zr < -cmp_pkg::PI_Q13) begin
        ang_next = cmp_pkg::ANG_W'(-cmp_pkg::PI_Q13);
      end else begin
        ang_next = cmp_pkg::ANG_W'(a_zr);
      end
    end
  end

  assign a_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && a_valid) begin
      magnitude <= mag_next;
      angle     <= ang_next;
    end
  end

endmodule

[rtl/complex_magnitude_phase.sv]
// Top level: magnitude and four-quadrant angle of a complex sample stream.
//
// Slave stream s_*: one complex sample per beat, real part in the low half of
// s_tdata and imaginary part above it, both two's complement.
// Master stream m_*: one result per sample, in order; magnitude (unsigned,
// rounded, saturated to 46341) in the low half of m_tdata, angle above it as
// signed Q3.13 radians (pi = 25736), zero for the origin.
// Path: an accepted beat is loaded into the entry stage register, then passes
// one register per micro-rotation, the multiply stage and the output register
// before it appears on m_tvalid.
// Throughput: one sample per clock while m_tready stays high; every stage is a
// register with its own valid bit, from the entry stage through the rotations to the output.
// Stalls: when m_tready is low, results hold and empty stages further up keep
// filling; s_tready falls only once every stage holds a beat.
// Reset (rst, synchronous): clears every valid bit; no result is pending
// afterwards and the block keeps no other state.
module complex_magnitude_phase (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [cmp_pkg::IN_TDATA_W-1:0]     s_tdata,   // re_part, im_part
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [cmp_pkg::OUT_TDATA_W-1:0]    m_tdata    // magnitude, angle
);

  localparam int DW = cmp_pkg::DATA_WIDTH;

  logic                              pre_valid;
  logic                              pre_ready;
  cmp_pkg::cmp_beat_t                pre_beat;
  logic                              rot_valid;
  logic                              rot_ready;
  cmp_pkg::cmp_beat_t                rot_beat;
  logic        [cmp_pkg::MAG_W-1:0]  magnitude;
  logic signed [cmp_pkg::ANG_W-1:0]  angle;

  cmp_prerot u_prerot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .re_part   (s_tdata[DW-1:0]),
    .im_part   (s_tdata[2*DW-1:DW]),
    .out_valid (pre_valid),
    .out_ready (pre_ready),
    .out_beat  (pre_beat)
  );

  cmp_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pre_valid),
    .in_ready  (pre_ready),
    .in_beat   (pre_beat),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_beat  (rot_beat)
  );

  cmp_post u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_beat   (rot_beat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .magnitude (magnitude),
    .angle     (angle)
  );

  // Pack the result, zero-filled to whole bytes
  assign m_tdata = cmp_pkg::OUT_TDATA_W'({angle, magnitude});

`ifndef NO_ASSERTIONS
  // Saturation never lets a magnitude above the limit through
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (magnitude <= cmp_pkg::MAG_W'(cmp_pkg::MAG_MAX)))
    else $error("magnitude above saturation limit");

  // Angle stays within plus or minus pi
  a_ang_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((angle <= cmp_pkg::PI_Q13) && (angle >= -cmp_pkg::PI_Q13)))
    else $error("angle outside plus or minus pi");

  // A draining output lets every stage advance, so the input is never held
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output drains");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result pending right after reset");
`endif

endmodule

[dv/complex_magnitude_phase_tb.sv]
// Stream testbench for the complex magnitude and phase pipeline, self-checking.
`timescale 1ns / 100ps

// Scoreboard: expected magnitude/angle pairs, oldest first
class magphase_scoreboard;
  bit [15:0] mag_q[$];
  bit [15:0] ang_q[$];
  int unsigned errors;
  int unsigned samples;
  int unsigned results;
  int unsigned axis_hits;
  int unsigned saturated;

  function int unsigned pending();
    return mag_q.size();
  endfunction

  // Modulus and Q3.13 atan2 angle of one sample, as the pipeline computes them
  function void polar_of(input logic signed [15:0] re_in, input logic signed [15:0] im_in,
                         output bit [15:0] mag, output bit [15:0] ang);
    longint re, im, x, y, z, dx, dy, m, a;
    re = re_in;
    im = im_in;
    if (re == 0 && im == 0) begin
      m = 0;
      a = 0;
    end else if (im == 0) begin
      m = (re < 0) ? -re : re;
      a = (re < 0) ? cmp_pkg::PI_Q13 : 0;
    end else if (re == 0) begin
      m = (im < 0) ? -im : im;
      a = (im < 0) ? -cmp_pkg::HALF_PI_Q13 : cmp_pkg::HALF_PI_Q13;
    end else begin
      // fold the left half-plane into the right by a quarter turn
      if (re > 0) begin
        x = re;
        y = im;
        z = 0;
      end else if (im > 0) begin
        x = im;
        y = -re;
        z = cmp_pkg::HALF_PI_Q30;
      end else begin
        x = -im;
        y = re;
        z = -longint'(cmp_pkg::HALF_PI_Q30);
      end
      x = x <<< cmp_pkg::GUARD;
      y = y <<< cmp_pkg::GUARD;
      // micro-rotations drive y towards zero
      for (int i = 0; i < cmp_pkg::NUM_STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx;
          y -= dy;
          z += longint'(cmp_pkg::ATAN_Q30[i]);
        end else begin
          x -= dx;
          y += dy;
          z -= longint'(cmp_pkg::ATAN_Q30[i]);
        end
      end
      if (x < 0) x = 0;
      m = (x * longint'(cmp_pkg::GAIN_Q22) + (64'sd1 <<< (cmp_pkg::GUARD + 21)))
          >>> cmp_pkg::MAG_SHIFT;
      a = (z + longint'(cmp_pkg::Z_ROUND)) >>> cmp_pkg::Z_SHIFT;
    end
    // saturate magnitude, clamp angle to +-pi
    if (m < 0) m = 0;
    if (m > cmp_pkg::MAG_MAX) m = cmp_pkg::MAG_MAX;
    if (a > cmp_pkg::PI_Q13) a = cmp_pkg::PI_Q13;
    if (a < -cmp_pkg::PI_Q13) a = -cmp_pkg::PI_Q13;
    mag = m[15:0];
    ang = a[15:0];
  endfunction

  // Record an accepted sample beat
  function void note_sample(input logic signed [15:0] re, input logic signed [15:0] im);
    bit [15:0] mag, ang;
    polar_of(re, im, mag, ang);
    mag_q.push_back(mag);
    ang_q.push_back(ang);
    samples++;
    if (re == 0 || im == 0) axis_hits++;
    if (mag == cmp_pkg::MAG_MAX) saturated++;
  endfunction

  // Compare one result beat with the oldest expectation
  function void check_result(input logic [cmp_pkg::OUT_TDATA_W-1:0] beat);
    bit [15:0] exp_mag, exp_ang;
    results++;
    if (mag_q.size() == 0) begin
      $error("result beat with no sample outstanding: tdata %h", beat);
      errors++;
      return;
    end
    exp_mag = mag_q.pop_front();
    exp_ang = ang_q.pop_front();
    if (beat[15:0] !== exp_mag) begin
      $error("magnitude mismatch: expected %0d, actual %0d", exp_mag, beat[15:0]);
      errors++;
    end
    if (beat[31:16] !== exp_ang) begin
      $error("angle mismatch: expected %0d, actual %0d",
             $signed(exp_ang), $signed(beat[31:16]));
      errors++;
    end
  endfunction
endclass

module complex_magnitude_phase_tb;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int RANDOM_SAMPLES = 650;
  localparam int NUM_DIRECTED   = 22;

  // Points on the axes, in every quadrant and at the range corners
  localparam int DIRECTED [NUM_DIRECTED][2] = '{
    '{0, 0}, '{32767, 0}, '{-32768, 0}, '{1, 0}, '{-1, 0},
    '{0, 32767}, '{0, -32768}, '{0, 1}, '{0, -1},
    '{3, 4}, '{-3, 4}, '{-3, -4}, '{3, -4},
    '{32767, 32767}, '{-32768, -32768}, '{-32768, 32767}, '{32767, -32768},
    '{-32768, 1}, '{-32768, -1}, '{1, -32768}, '{-1, 32767}, '{-1, -1}
  };

  typedef enum int {RX_STREAM, RX_BUSY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                            clk;
  logic                            rst      = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [cmp_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;   // re_part, im_part
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [cmp_pkg::OUT_TDATA_W-1:0] m_tdata;         // magnitude, angle

  magphase_scoreboard sb = new();
  int unsigned cycles  = 0;
  rx_mode_t    rx_mode = RX_STREAM;
  int unsigned rx_left = 0;

  complex_magnitude_phase dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure: switch to a random pattern each time rx_left runs out
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_STREAM:   m_tready <= 1'b1;
      RX_BUSY:     m_tready <= ($urandom_range(0, 9) < 7);
      RX_SPARSE:   m_tready <= ($urandom_range(0, 9) < 3);
      RX_PERIODIC: m_tready <= ((rx_left % 5) != 0);
      default:     m_tready <= 1'b1;
    endcase
  end

  // Check every result beat taken
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Guard against a hung pipeline
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // Offer one sample at a falling edge and hold it until the beat is taken
  task automatic send_sample(input logic [15:0] re, input logic [15:0] im);
    s_tdata  <= {im, re};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(re, im);
    @(negedge clk);
  endtask

  // Drop valid and put junk on the data lines, for a gap whose length is set by n
  task automatic hold_off(input int unsigned n);
    s_tvalid <= 1'b0;
    s_tdata  <= cmp_pkg::IN_TDATA_W'($urandom);
    repeat (n) @(negedge clk);
  endtask

  // Stop sending until every result is back, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (cmp_pkg::NUM_STAGES + 4) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] extreme_value();
    case ($urandom_range(0, 6))
      0:       return 16'h8000;
      1:       return 16'h8001;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      4:       return 16'h0001;
      5:       return 16'h7FFE;
      default: return 16'h7FFF;
    endcase
  endfunction

  // Mix of full-range, small, mid-range, axis, near-axis and corner samples
  task automatic random_sample(output logic [15:0] re, output logic [15:0] im);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      re = 16'($urandom);
      im = 16'($urandom);
    end else if (pick < 55) begin
      re = 16'($urandom_range(0, 64) - 32);
      im = 16'($urandom_range(0, 64) - 32);
    end else if (pick < 65) begin
      re = 16'($urandom);
      im = 16'h0000;
      if ($urandom_range(0, 1)) begin
        im = re;
        re = 16'h0000;
      end
    end else if (pick < 80) begin
      re = 16'($urandom);
      im = 16'($urandom_range(0, 6) - 3);
      if ($urandom_range(0, 1)) begin
        im = re;
        re = 16'($urandom_range(0, 6) - 3);
      end
    end else if (pick < 90) begin
      re = extreme_value();
      im = extreme_value();
    end else begin
      re = 16'($urandom_range(0, 4096) - 2048);
      im = 16'($urandom_range(0, 4096) - 2048);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    bit          paused;
    logic [15:0] re, im;
    sent   = 0;
    paused = 1'b0;

    // Reset once, release on a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corner cases
    for (int k = 0; k < NUM_DIRECTED; k++) begin
      send_sample(16'(DIRECTED[k][0]), 16'(DIRECTED[k][1]));
      if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 4));
    end
    drain();

    // Random bursts with random gaps, one full drain half way
    while (sent < RANDOM_SAMPLES) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        random_sample(re, im);
        send_sample(re, im);
        sent++;
      end
      if (!paused && sent >= RANDOM_SAMPLES / 2) begin
        drain();
        paused = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        hold_off($urandom_range(1, 8));
      end
    end
    drain();

    $display("Sent %0d samples (%0d on an axis or at the origin, %0d with saturated magnitude)",
             sb.samples, sb.axis_hits, sb.saturated);
    $display("Compared %0d result beats under varying back-pressure, %0d mismatches",
             sb.results, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
